@@ rtl/core/cidd_pkg.sv @@
package cidd_pkg;

    // Field and register widths.
    localparam int SAMPLE_W    = 16;
    localparam int SINE_W      = 16;
    localparam int PHASE_W     = 16;
    localparam int STEP_W      = 16;
    localparam int MODE_W      = 2;
    localparam int LEN_W       = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int INTEGRAL_W  = 32;
    localparam int MIX_PROD_W  = SAMPLE_W + SINE_W;
    localparam int DEC_PROD_W  = INTEGRAL_W + STEP_W + 1;

    // Slot and carrier table geometry.
    localparam int MAX_SLOT_LENGTH = 1024;
    localparam int POS_W           = $clog2(MAX_SLOT_LENGTH);
    localparam int SINE_TABLE_SIZE = 256;
    localparam int SINE_IDX_W      = $clog2(SINE_TABLE_SIZE);

    // Fixed-point constants: unity carrier in Q1.14, mixer fraction bits,
    // decision level in Q4.11 and the thresholds on the Q.27 product.
    localparam int SINE_UNITY     = 16384;
    localparam int MIX_FRAC       = 14;
    localparam int DECISION_LEVEL = 2048;
    localparam longint THR_BASE   = 64'sd67108864;
    localparam longint THR_EXTRA  = 64'sd33554432;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [MODE_W-1:0] {
        MODE_AMPLITUDE = 2'd0,
        MODE_PHASE     = 2'd1,
        MODE_BASEBAND  = 2'd2
    } mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MODE         = 2'd0,
        CFG_SLOT_LENGTH  = 2'd1,
        CFG_SAMPLE_STEP  = 2'd2,
        CFG_CARRIER_STEP = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [LEN_W-1:0]   slot_length;
        logic [STEP_W-1:0]  sample_step;
        logic [PHASE_W-1:0] carrier_step;
    } cidd_cfg_t;

    // One classified sample as it travels from front to back.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic signed [SINE_W-1:0]   sine;
        logic                       frame_start;
        logic                       slot_boundary;
    } cidd_item_t;

    typedef logic signed [SINE_W-1:0] sine_table_t [SINE_TABLE_SIZE];

    localparam longint Q30 = 64'sd1073741824;

    function automatic longint qmul30(longint a, longint b);
        return (a * b) / Q30;
    endfunction

    // Odd polynomial for a quarter wave, Q2.30 in, Q1.14 out.
    function automatic longint quarter_sine(longint y);
        longint y2;
        longint p;
        longint s;
        longint v;
        y2 = qmul30(y, y);
        p  = 64'sd172273;
        p  = -64'sd5026995 + qmul30(p, y2);
        p  = 64'sd85569306 + qmul30(p, y2);
        p  = -64'sd693598668 + qmul30(p, y2);
        p  = 64'sd1686629713 + qmul30(p, y2);
        s  = qmul30(p, y);
        if (s < 0)
        begin
            s = 0;
        end
        v = (s + 64'sd32768) / 64'sd65536;
        if (v > SINE_UNITY)
        begin
            v = SINE_UNITY;
        end
        return v;
    endfunction

    // Full-wave sine table, worked out at elaboration.
    function automatic sine_table_t build_sine_table();
        sine_table_t t;
        longint f;
        longint q;
        longint r;
        longint y;
        longint v;
        for (int k = 0; k < SINE_TABLE_SIZE; k++)
        begin
            f = 4 * longint'(k);
            q = f / SINE_TABLE_SIZE;
            r = f % SINE_TABLE_SIZE;
            y = (r <<< 30) / SINE_TABLE_SIZE;
            if (q[0])
            begin
                y = Q30 - y;
            end
            v = quarter_sine(y);
            t[k] = SINE_W'((q >= 2) ? -v : v);
        end
        return t;
    endfunction

    localparam sine_table_t SINE_TABLE = build_sine_table();

endpackage

@@ rtl/core/cidd_if.sv @@
interface cidd_in_if import cidd_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       frame_start;

    modport source (output valid, output sample, output frame_start, input ready);
    modport sink (input valid, input sample, input frame_start, output ready);
endinterface

interface cidd_out_if import cidd_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] out_value;
    logic                       is_decision;
    logic                       decision_bit;

    modport source (output valid, output out_value, output is_decision,
                    output decision_bit, input ready);
    modport sink (input valid, input out_value, input is_decision,
                  input decision_bit, output ready);
endinterface

@@ rtl/core/cidd_front.sv @@
module cidd_front import cidd_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  cidd_cfg_t    cfg,
    cidd_in_if.sink      in_ch,
    output logic         push,
    output cidd_item_t   push_item,
    input  logic         q_full
);

    logic [PHASE_W-1:0]    phase_reg;
    logic [PHASE_W-1:0]    phase_next;
    logic [POS_W-1:0]      pos_reg;
    logic [POS_W-1:0]      pos_next;
    logic [PHASE_W-1:0]    cur_phase;
    logic [POS_W-1:0]      cur_pos;
    logic [POS_W:0]        pos_inc;
    logic [LEN_W-1:0]      len;
    logic [SINE_IDX_W-1:0] sine_idx;
    logic                  mixing;

    // A beat is taken whenever the queue has room.
    assign in_ch.ready = !q_full;
    assign push        = in_ch.valid && !q_full;

    // Slot length held to its legal range.
    always_comb
    begin
        if (cfg.slot_length == '0)
        begin
            len = LEN_W'(1);
        end
        else if (cfg.slot_length > LEN_W'(MAX_SLOT_LENGTH))
        begin
            len = LEN_W'(MAX_SLOT_LENGTH);
        end
        else
        begin
            len = cfg.slot_length;
        end
    end

    // Carrier lookup and slot position for the incoming sample.
    always_comb
    begin
        cur_phase = in_ch.frame_start ? '0 : phase_reg;
        cur_pos   = in_ch.frame_start ? '0 : pos_reg;
        sine_idx  = cur_phase[PHASE_W-1 -: SINE_IDX_W];
        mixing    = (cfg.mode == MODE_AMPLITUDE) || (cfg.mode == MODE_PHASE);

        push_item.sample        = in_ch.sample;
        push_item.sine          = mixing ? SINE_TABLE[sine_idx] : SINE_W'(SINE_UNITY);
        push_item.frame_start   = in_ch.frame_start;
        push_item.slot_boundary = !in_ch.frame_start && (cur_pos == '0);

        pos_inc    = {1'b0, cur_pos} + (POS_W + 1)'(1);
        pos_next   = (pos_inc >= len) ? '0 : pos_inc[POS_W-1:0];
        phase_next = cur_phase + cfg.carrier_step;
    end

    // Phase accumulator and slot counter advance once per accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            pos_reg   <= '0;
        end
        else if (push)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

@@ rtl/core/cidd_queue.sv @@
module cidd_queue import cidd_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  cidd_item_t push_item,
    output logic       full,
    input  logic       pop,
    output cidd_item_t pop_item,
    output logic       not_empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cidd_item_t       mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = mem[rd_ptr_reg];

    // Pointer and fill count bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (!push && pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage for queued beats.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ rtl/core/cidd_back.sv @@
module cidd_back import cidd_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  cidd_cfg_t   cfg,
    input  logic        q_not_empty,
    input  cidd_item_t  pop_item,
    output logic        pop,
    cidd_out_if.source  out_ch
);

    // Pipeline control.
    logic advance;
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic out_valid_reg;

    // Mixer stage.
    logic signed [MIX_PROD_W-1:0]   s1_prod_reg;
    logic                           s1_start_reg;
    logic                           s1_bound_reg;

    // Integration stage.
    logic signed [MIX_PROD_W:0]     rnd;
    logic signed [MIX_PROD_W-MIX_FRAC:0] shifted;
    logic signed [SAMPLE_W-1:0]     mixed;
    logic signed [INTEGRAL_W+1:0]   wide_sum;
    logic signed [INTEGRAL_W-1:0]   sum_sat;
    logic signed [INTEGRAL_W-1:0]   integral_reg;
    logic signed [INTEGRAL_W-1:0]   integral_next;
    logic signed [SAMPLE_W-1:0]     prev_reg;
    logic signed [SAMPLE_W-1:0]     s2_mixed_reg;
    logic signed [INTEGRAL_W-1:0]   s2_sum_reg;
    logic                           s2_start_reg;
    logic                           s2_bound_reg;

    // Decision product stage.
    logic signed [DEC_PROD_W-1:0]   s3_prod_reg;
    logic signed [SAMPLE_W-1:0]     s3_mixed_reg;
    logic                           s3_start_reg;
    logic                           s3_bound_reg;

    // Decision and output stage.
    logic signed [DEC_PROD_W-1:0]   threshold;
    logic                           held_reg;
    logic                           held_next;
    logic                           ready_reg;
    logic                           ready_next;
    logic signed [SAMPLE_W-1:0]     out_value_reg;
    logic signed [SAMPLE_W-1:0]     out_value_next;
    logic                           is_decision_reg;
    logic                           decision_bit_reg;

    // The whole pipeline moves whenever the output register can move.
    assign advance = !out_valid_reg || out_ch.ready;
    assign pop     = advance && q_not_empty;

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.out_value    = out_value_reg;
    assign out_ch.is_decision  = is_decision_reg;
    assign out_ch.decision_bit = decision_bit_reg;

    // Round the mixer product back to Q4.11, then add the pair into the slot.
    always_comb
    begin
        rnd     = (MIX_PROD_W + 1)'(s1_prod_reg) + (MIX_PROD_W + 1)'(1 <<< (MIX_FRAC - 1));
        shifted = (MIX_PROD_W - MIX_FRAC + 1)'(rnd >>> MIX_FRAC);
        if (shifted > (MIX_PROD_W - MIX_FRAC + 1)'(32767))
        begin
            mixed = 16'sh7FFF;
        end
        else if (shifted < -(MIX_PROD_W - MIX_FRAC + 1)'(32768))
        begin
            mixed = 16'sh8000;
        end
        else
        begin
            mixed = shifted[SAMPLE_W-1:0];
        end

        wide_sum = (INTEGRAL_W + 2)'(integral_reg) + (INTEGRAL_W + 2)'(prev_reg)
                 + (INTEGRAL_W + 2)'(mixed);
        if (wide_sum > (INTEGRAL_W + 2)'(34'sh0_7FFF_FFFF))
        begin
            sum_sat = 32'sh7FFF_FFFF;
        end
        else if (wide_sum < (INTEGRAL_W + 2)'(-34'sh0_8000_0000))
        begin
            sum_sat = 32'sh8000_0000;
        end
        else
        begin
            sum_sat = wide_sum[INTEGRAL_W-1:0];
        end

        if (s1_start_reg || s1_bound_reg)
        begin
            integral_next = '0;
        end
        else
        begin
            integral_next = sum_sat;
        end
    end

    // Decision on the dumped slot and choice of the value to show.
    always_comb
    begin
        threshold = DEC_PROD_W'(THR_BASE);
        if (cfg.mode == MODE_AMPLITUDE)
        begin
            threshold = DEC_PROD_W'(THR_BASE + THR_EXTRA);
        end
        held_next  = held_reg;
        ready_next = ready_reg;
        if (s3_start_reg)
        begin
            held_next  = 1'b0;
            ready_next = 1'b0;
        end
        else if (s3_bound_reg)
        begin
            held_next  = (s3_prod_reg >= threshold);
            ready_next = 1'b1;
        end
        if (ready_next)
        begin
            out_value_next = held_next ? SAMPLE_W'(DECISION_LEVEL)
                                       : -SAMPLE_W'(DECISION_LEVEL);
        end
        else
        begin
            out_value_next = s3_mixed_reg;
        end
    end

    // Stage valid flags and the state carried from sample to sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            integral_reg  <= '0;
            prev_reg      <= '0;
            held_reg      <= 1'b0;
            ready_reg     <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= q_not_empty;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
            if (s1_valid_reg)
            begin
                integral_reg <= integral_next;
                prev_reg     <= mixed;
            end
            if (s3_valid_reg)
            begin
                held_reg  <= held_next;
                ready_reg <= ready_next;
            end
        end
    end

    // Payload registers of each stage.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_prod_reg      <= MIX_PROD_W'(pop_item.sample * pop_item.sine);
            s1_start_reg     <= pop_item.frame_start;
            s1_bound_reg     <= pop_item.slot_boundary;
            s2_mixed_reg     <= mixed;
            s2_sum_reg       <= sum_sat;
            s2_start_reg     <= s1_start_reg;
            s2_bound_reg     <= s1_bound_reg;
            s3_prod_reg      <= DEC_PROD_W'(s2_sum_reg * $signed({1'b0, cfg.sample_step}));
            s3_mixed_reg     <= s2_mixed_reg;
            s3_start_reg     <= s2_start_reg;
            s3_bound_reg     <= s2_bound_reg;
            out_value_reg    <= out_value_next;
            is_decision_reg  <= ready_next;
            decision_bit_reg <= ready_next && held_next;
        end
    end

endmodule

@@ rtl/core/coherent_integrate_dump_demodulator.sv @@
// An accepted input beat passes the queue, mixer product, integration,
// decision product and output registers before its result is valid.
// Throughput: one beat per cycle while the output is taken; the queue lets
// the input keep going for up to 4 beats while the output stalls.
// Reset: configuration returns to its defaults and carrier phase, slot state,
// integral and held decision clear at once; no clearing pass is needed.
module coherent_integrate_dump_demodulator import cidd_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    cidd_in_if.sink                in_ch,
    cidd_out_if.source             out_ch,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cidd_cfg_t  cfg_reg;
    cidd_item_t push_item;
    cidd_item_t pop_item;
    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_not_empty;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode         <= MODE_AMPLITUDE;
            cfg_reg.slot_length  <= LEN_W'(10);
            cfg_reg.sample_step  <= STEP_W'(655);
            cfg_reg.carrier_step <= PHASE_W'(1311);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:         cfg_reg.mode         <= cfg_data[MODE_W-1:0];
                CFG_SLOT_LENGTH:  cfg_reg.slot_length  <= cfg_data[LEN_W-1:0];
                CFG_SAMPLE_STEP:  cfg_reg.sample_step  <= cfg_data[STEP_W-1:0];
                CFG_CARRIER_STEP: cfg_reg.carrier_step <= cfg_data[PHASE_W-1:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // Front: takes beats, looks up the carrier and marks slot boundaries.
    cidd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_ch     (in_ch),
        .push      (q_push),
        .push_item (push_item),
        .q_full    (q_full)
    );

    // Queue between front and back.
    cidd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .not_empty (q_not_empty)
    );

    // Back: mixes, integrates, decides and presents results.
    cidd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .pop_item    (pop_item),
        .pop         (q_pop),
        .out_ch      (out_ch)
    );

    // A decision always carries the matching level.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.is_decision |->
            (out_ch.out_value == 16'sd2048 && out_ch.decision_bit) ||
            (out_ch.out_value == -16'sd2048 && !out_ch.decision_bit))
        else $error("decision level does not match decision bit");

    // A raw mixed sample never carries a decision bit.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.is_decision |-> !out_ch.decision_bit)
        else $error("decision bit set on a non-decision beat");

    // The input is only held off while the queue holds beats.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> q_not_empty)
        else $error("input stalled with an empty queue");

    // The back never pops an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_not_empty)
        else $error("pop from an empty queue");

endmodule
